// ===== hw/rtl/spf_pkg.sv =====
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants for the servo packet framer with CRC-16.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam logic [7:0]  HDR_SYNC = 8'hFF;
    localparam logic [7:0]  HDR_MARK = 8'hFD;
    localparam logic [7:0]  HDR_RSV  = 8'h00;
    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // which byte of the held word goes out next
    typedef enum logic [6:0] {
        PH_HDR0   = 7'b0000001,
        PH_HDR1   = 7'b0000010,
        PH_HDR2   = 7'b0000100,
        PH_HDR3   = 7'b0001000,
        PH_BODY   = 7'b0010000,
        PH_CRC_LO = 7'b0100000,
        PH_CRC_HI = 7'b1000000
    } phase_t;

endpackage

// ===== hw/rtl/spf_crc_byte.sv =====
// ----------------------------------------------------------------------------
// spf_crc_byte
// One byte of CRC-16 update, polynomial 0x8005, MSB first, no reflection.
// ----------------------------------------------------------------------------
module spf_crc_byte (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);
    import spf_pkg::*;

    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

// ===== hw/rtl/servo_packet_framer_crc16.sv =====
// ----------------------------------------------------------------------------
// servo_packet_framer_crc16
// Frames instruction packet body bytes with header and trailing CRC-16.
// ----------------------------------------------------------------------------
// Usage:
//   s_ side takes body bytes (ID, length lo/hi, instruction, params), one
//   per word; s_tlast marks the final body byte of a packet.
//   m_ side sends the framed stream: FF FF FD 00 before the first body byte
//   of a packet, body bytes unchanged, then CRC low and CRC high after the
//   last byte. m_tlast is high on the CRC high byte only.
//   CRC-16: poly 0x8005, init 0, MSB first, over header and body.
// Path: an accepted word is held in the hold register, and each byte it
//   emits is loaded into the output register that drives m_.
// Throughput: one output byte per cycle while m_tready is high. One input
//   word per cycle inside a frame; the first word of a packet sends five
//   bytes (header and body), the last word three (body and CRC), a one-byte
//   packet seven; output is the limit, one byte of a held word per cycle.
// Reset: clears the held-word and output valid flags and the frame state; the next
//   byte starts a new frame.
// Stall: with m_tready low the output register holds and the held word
//   waits; s_tready drops until the held word has sent its last byte.
// ----------------------------------------------------------------------------
module servo_packet_framer_crc16 (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] body_byte
    input  logic       s_tlast,   // body_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] tx_byte
    output logic       m_tlast    // frame_end
);
    import spf_pkg::*;

    // held input word and its emission phase
    logic        hold_valid_reg, hold_valid_next;
    logic [7:0]  hold_byte_reg,  hold_byte_next;
    logic        hold_last_reg,  hold_last_next;
    phase_t      phase_reg,      phase_next;

    // frame state
    logic        in_frame_reg,   in_frame_next;
    logic [15:0] crc_reg,        crc_next;

    // output register
    logic        out_valid_reg,  out_valid_next;
    logic [7:0]  out_data_reg,   out_data_next;
    logic        out_last_reg,   out_last_next;

    // emission logic
    logic        advance;
    logic        finish;
    logic        accept;
    logic        feed_en;
    logic [7:0]  emit_byte;
    logic        emit_last;
    phase_t      phase_adv;
    logic [15:0] crc_base;
    logic [15:0] crc_fed;

    assign advance = hold_valid_reg && (!out_valid_reg || m_tready);

    always_comb begin
        emit_byte = hold_byte_reg;
        emit_last = 1'b0;
        feed_en   = 1'b0;
        finish    = 1'b0;
        phase_adv = phase_reg;
        case (phase_reg)
            PH_HDR0: begin
                emit_byte = HDR_SYNC;
                feed_en   = 1'b1;
                phase_adv = PH_HDR1;
            end
            PH_HDR1: begin
                emit_byte = HDR_SYNC;
                feed_en   = 1'b1;
                phase_adv = PH_HDR2;
            end
            PH_HDR2: begin
                emit_byte = HDR_MARK;
                feed_en   = 1'b1;
                phase_adv = PH_HDR3;
            end
            PH_HDR3: begin
                emit_byte = HDR_RSV;
                feed_en   = 1'b1;
                phase_adv = PH_BODY;
            end
            PH_BODY: begin
                emit_byte = hold_byte_reg;
                feed_en   = 1'b1;
                finish    = !hold_last_reg;
                phase_adv = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                emit_byte = crc_reg[7:0];
                phase_adv = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                emit_byte = crc_reg[15:8];
                emit_last = 1'b1;
                finish    = 1'b1;
                phase_adv = PH_HDR0;
            end
            default: begin
                emit_byte = hold_byte_reg;
                finish    = 1'b1;
                phase_adv = PH_HDR0;
            end
        endcase
    end

    // a new frame restarts the CRC from its initial value
    assign crc_base = (phase_reg == PH_HDR0) ? CRC_INIT : crc_reg;

    spf_crc_byte u_crc (
        .crc_in  (crc_base),
        .data_in (emit_byte),
        .crc_out (crc_fed)
    );

    assign s_tready = !hold_valid_reg || (advance && finish);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        in_frame_next   = in_frame_reg;
        crc_next        = crc_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        hold_last_next  = hold_last_reg;
        phase_next      = phase_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;

        if (advance) begin
            out_valid_next = 1'b1;
            out_data_next  = emit_byte;
            out_last_next  = emit_last;
            if (feed_en) begin
                crc_next = crc_fed;
            end
            if (phase_reg == PH_BODY) begin
                in_frame_next = !hold_last_reg;
            end
            phase_next = phase_adv;
            if (finish) begin
                hold_valid_next = 1'b0;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (accept) begin
            hold_valid_next = 1'b1;
            hold_byte_next  = s_tdata;
            hold_last_next  = s_tlast;
            phase_next      = in_frame_next ? PH_BODY : PH_HDR0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= PH_HDR0;
            in_frame_reg   <= 1'b0;
            crc_reg        <= CRC_INIT;
            out_valid_reg  <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
            in_frame_reg   <= in_frame_next;
            crc_reg        <= crc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        hold_byte_reg <= hold_byte_next;
        hold_last_reg <= hold_last_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
